// ===== hdl/complex_arithmetic_unit_macros.svh =====
// ----------------------------------------------------------------------------
// complex_arithmetic_unit_macros : assertion helpers
// Clocked, reset-qualified assertion macros for the complex arithmetic unit.
// ----------------------------------------------------------------------------
`ifndef COMPLEX_ARITHMETIC_UNIT_MACROS_SVH
`define COMPLEX_ARITHMETIC_UNIT_MACROS_SVH

// Property checked on every rising clock edge while out of reset.
`define CAU_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Property checked on every rising clock edge, reset included.
`define CAU_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== hdl/cau_pkg.sv =====
// ----------------------------------------------------------------------------
// cau_pkg : shared types of the complex arithmetic unit
// Operation codes and the side data carried beside the divider pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package cau_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned OPND_W = 16;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    // Everything the output stage needs besides the two quotients.
    typedef struct packed {
        op_t               op;
        logic [DATA_W-1:0] re;
        logic [DATA_W-1:0] im;
        logic              zf;
        logic              neg_re;
        logic              neg_im;
    } tag_t;

    // Result of the front stages.
    typedef struct packed {
        tag_t              tag;
        logic [DATA_W-1:0] mag_re;
        logic [DATA_W-1:0] mag_im;
        logic [DATA_W-1:0] den;
    } front_t;

endpackage

`default_nettype wire

// ===== hdl/cau_front.sv =====
// ----------------------------------------------------------------------------
// cau_front : product and sum stages
// Stage one forms the six operand products, stage two the sums, the
// shifted multiply result, the divide numerator magnitudes and |b|^2.
// ----------------------------------------------------------------------------
`default_nettype none

module cau_front #(
    parameter int FRAC_BITS = 8
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          en,
    input  wire logic                          in_valid,
    input  wire logic [1:0]                    in_op,
    input  wire logic signed [15:0]            in_a_re,
    input  wire logic signed [15:0]            in_a_im,
    input  wire logic signed [15:0]            in_b_re,
    input  wire logic signed [15:0]            in_b_im,
    output logic                               out_valid,
    output cau_pkg::front_t                    out_data
);
    import cau_pkg::*;

    logic              v1_reg;
    op_t               op1_reg;
    logic signed [15:0] ar_reg, ai_reg, br_reg, bi_reg;
    logic signed [31:0] p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg, s_rr_reg, s_ii_reg;

    logic              v2_reg;
    front_t            f2_reg;
    front_t            f2_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            op1_reg  <= op_t'(in_op);
            ar_reg   <= in_a_re;
            ai_reg   <= in_a_im;
            br_reg   <= in_b_re;
            bi_reg   <= in_b_im;
            p_rr_reg <= in_a_re * in_b_re;
            p_ii_reg <= in_a_im * in_b_im;
            p_ri_reg <= in_a_re * in_b_im;
            p_ir_reg <= in_a_im * in_b_re;
            s_rr_reg <= in_b_re * in_b_re;
            s_ii_reg <= in_b_im * in_b_im;
            f2_reg   <= f2_next;
        end
    end

    logic signed [32:0] mul_re, mul_im, num_re, num_im;
    logic signed [32:0] mul_re_sh, mul_im_sh;
    logic        [32:0] mag_re, mag_im;
    logic        [31:0] den;

    always_comb begin
        mul_re    = 33'(p_rr_reg) - 33'(p_ii_reg);
        mul_im    = 33'(p_ri_reg) + 33'(p_ir_reg);
        num_re    = 33'(p_rr_reg) + 33'(p_ii_reg);
        num_im    = 33'(p_ir_reg) - 33'(p_ri_reg);
        mul_re_sh = mul_re >>> FRAC_BITS;
        mul_im_sh = mul_im >>> FRAC_BITS;
        mag_re    = num_re[32] ? 33'(-num_re) : 33'(num_re);
        mag_im    = num_im[32] ? 33'(-num_im) : 33'(num_im);
        den       = $unsigned(s_rr_reg) + $unsigned(s_ii_reg);

        f2_next            = '0;
        f2_next.tag.op     = op1_reg;
        f2_next.tag.neg_re = num_re[32];
        f2_next.tag.neg_im = num_im[32];
        f2_next.tag.zf     = (op1_reg == OP_DIV) && (den == '0);
        f2_next.mag_re     = mag_re[31:0];
        f2_next.mag_im     = mag_im[31:0];
        f2_next.den        = den;
        case (op1_reg)
            OP_ADD: begin
                f2_next.tag.re = 32'(ar_reg) + 32'(br_reg);
                f2_next.tag.im = 32'(ai_reg) + 32'(bi_reg);
            end
            OP_SUB: begin
                f2_next.tag.re = 32'(ar_reg) - 32'(br_reg);
                f2_next.tag.im = 32'(ai_reg) - 32'(bi_reg);
            end
            OP_MUL: begin
                f2_next.tag.re = mul_re_sh[31:0];
                f2_next.tag.im = mul_im_sh[31:0];
            end
            default: begin
                f2_next.tag.re = '0;
                f2_next.tag.im = '0;
            end
        endcase
    end

    assign out_valid = v2_reg;
    assign out_data  = f2_reg;

endmodule

`default_nettype wire

// ===== hdl/cau_div.sv =====
// ----------------------------------------------------------------------------
// cau_div : pipelined restoring divider
// One quotient bit per stage, NW stages, side tag carried with each item.
// ----------------------------------------------------------------------------
`default_nettype none

module cau_div #(
    parameter int NW    = 40,
    parameter int TAG_W = 1
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                en,
    input  wire logic                in_valid,
    input  wire logic [NW-1:0]       in_dividend,
    input  wire logic [31:0]         in_divisor,
    input  wire logic [TAG_W-1:0]    in_tag,
    output logic                     out_valid,
    output logic [NW-1:0]            out_quot,
    output logic [TAG_W-1:0]         out_tag
);

    logic              v_reg   [NW];
    logic [31:0]       rem_reg [NW];
    logic [NW-1:0]     dq_reg  [NW];
    logic [31:0]       den_reg [NW];
    logic [TAG_W-1:0]  tag_reg [NW];

    for (genvar i = 0; i < NW; i++) begin : g_stage
        logic              vp;
        logic [31:0]       rp, dp;
        logic [NW-1:0]     qp;
        logic [TAG_W-1:0]  tp;
        logic [32:0]       trial;
        logic              fits;

        if (i == 0) begin : g_first
            assign vp = in_valid;
            assign rp = '0;
            assign qp = in_dividend;
            assign dp = in_divisor;
            assign tp = in_tag;
        end else begin : g_next
            assign vp = v_reg[i-1];
            assign rp = rem_reg[i-1];
            assign qp = dq_reg[i-1];
            assign dp = den_reg[i-1];
            assign tp = tag_reg[i-1];
        end

        assign trial = {rp, qp[NW-1]};
        assign fits  = trial >= {1'b0, dp};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[i] <= 1'b0;
            end else if (en) begin
                v_reg[i] <= vp;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[i] <= fits ? 32'(trial - {1'b0, dp}) : trial[31:0];
                dq_reg[i]  <= {qp[NW-2:0], fits};
                den_reg[i] <= dp;
                tag_reg[i] <= tp;
            end
        end
    end

    assign out_valid = v_reg[NW-1];
    assign out_quot  = dq_reg[NW-1];
    assign out_tag   = tag_reg[NW-1];

endmodule

`default_nettype wire

// ===== hdl/complex_arithmetic_unit.sv =====
// ----------------------------------------------------------------------------
// complex_arithmetic_unit : pipelined complex add, subtract, multiply, divide
// Operands in signed Q7.8, results in signed Q23.8; divide saturates.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel s_*: one transfer carries s_req_type and operands a and b.
//   Result channel m_*: one transfer per request, in request order, with
//   m_res_re, m_res_im and m_zero_divisor.
//   Throughput: one request per cycle, sustained while m_ready does not stall the output.
//   Path from input transfer to m_valid: two product/sum stages, then the
//   restoring divider, which retires one quotient bit per stage over
//   32 + FRAC_BITS stages, then the output register.
//   All operations travel through the full pipeline so results stay ordered.
//   Stall: while m_valid is high and m_ready low, the whole pipeline holds
//   and s_ready drops; nothing is lost or repeated.
//   Reset: aresetn low for one clock clears every valid bit; no results are
//   pending afterwards. Data registers are not reset.
//   Divide by zero (b = 0): result zero with m_zero_divisor set.
// ----------------------------------------------------------------------------
`default_nettype none

`include "complex_arithmetic_unit_macros.svh"

module complex_arithmetic_unit #(
    parameter int FRAC_BITS = 8
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [1:0]         s_req_type,
    input  wire logic signed [15:0] s_a_re,
    input  wire logic signed [15:0] s_a_im,
    input  wire logic signed [15:0] s_b_re,
    input  wire logic signed [15:0] s_b_im,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [31:0]      m_res_re,
    output logic signed [31:0]      m_res_im,
    output logic                    m_zero_divisor
);
    import cau_pkg::*;

    // Dividend is the numerator magnitude scaled by 2^FRAC_BITS.
    localparam int NW    = DATA_W + FRAC_BITS;
    localparam int TAG_W = $bits(tag_t);

    localparam logic [NW-1:0] Q_MIN_MAG = NW'(64'h8000_0000);

    // Advance the whole pipe unless the output register is stalled.
    logic en;
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    logic   fr_valid;
    front_t fr_data;

    cau_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid),
        .in_op     (s_req_type),
        .in_a_re   (s_a_re),
        .in_a_im   (s_a_im),
        .in_b_re   (s_b_re),
        .in_b_im   (s_b_im),
        .out_valid (fr_valid),
        .out_data  (fr_data)
    );

    // Real divider carries the side tag; imaginary one carries only the imaginary sign.
    logic              dv_valid;
    logic [NW-1:0]     q_re, q_im;
    logic [TAG_W-1:0]  dv_tag_bits;
    logic              dv_im_valid;
    logic [0:0]        dv_im_tag;
    tag_t              dv_tag;

    cau_div #(
        .NW    (NW),
        .TAG_W (TAG_W)
    ) u_div_re (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (en),
        .in_valid    (fr_valid),
        .in_dividend (NW'(fr_data.mag_re) << FRAC_BITS),
        .in_divisor  (fr_data.den),
        .in_tag      (fr_data.tag),
        .out_valid   (dv_valid),
        .out_quot    (q_re),
        .out_tag     (dv_tag_bits)
    );

    cau_div #(
        .NW    (NW),
        .TAG_W (1)
    ) u_div_im (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (en),
        .in_valid    (fr_valid),
        .in_dividend (NW'(fr_data.mag_im) << FRAC_BITS),
        .in_divisor  (fr_data.den),
        .in_tag      (fr_data.tag.neg_im),
        .out_valid   (dv_im_valid),
        .out_quot    (q_im),
        .out_tag     (dv_im_tag)
    );

    assign dv_tag = tag_t'(dv_tag_bits);

    // Saturate a magnitude quotient and apply its sign.
    function automatic logic [31:0] sat_q(input logic [NW-1:0] q, input logic neg);
        logic [31:0] r;
        if (neg) begin
            r = (q > Q_MIN_MAG) ? 32'h8000_0000 : 32'(-q[31:0]);
        end else begin
            r = (q >= Q_MIN_MAG) ? 32'h7FFF_FFFF : q[31:0];
        end
        return r;
    endfunction

    logic        m_valid_reg, m_valid_next;
    logic [31:0] m_re_reg, m_re_next;
    logic [31:0] m_im_reg, m_im_next;
    logic        m_zf_reg, m_zf_next;

    always_comb begin
        m_valid_next = dv_valid;
        m_zf_next    = dv_tag.zf;
        if (dv_tag.op == OP_DIV) begin
            if (dv_tag.zf) begin
                m_re_next = '0;
                m_im_next = '0;
            end else begin
                m_re_next = sat_q(q_re, dv_tag.neg_re);
                m_im_next = sat_q(q_im, dv_im_tag[0]);
            end
        end else begin
            m_re_next = dv_tag.re;
            m_im_next = dv_tag.im;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_re_reg <= m_re_next;
            m_im_reg <= m_im_next;
            m_zf_reg <= m_zf_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_res_re       = m_re_reg;
    assign m_res_im       = m_im_reg;
    assign m_zero_divisor = m_zf_reg;

    // Flagged divides return zero.
    `CAU_ASSERT(a_zf_zero, aclk, aresetn, (m_valid && m_zero_divisor) |-> (m_res_re == 32'sd0 && m_res_im == 32'sd0), "zero divisor result not zero")
    // Both dividers hold items in lockstep.
    `CAU_ASSERT(a_div_lockstep, aclk, aresetn, dv_valid == dv_im_valid, "divider lanes out of step")
    // Reset empties the output.
    `CAU_ASSERT_ALWAYS(a_reset_clear, aclk, !aresetn |=> !m_valid, "result valid after reset")

endmodule

`default_nettype wire
